FILE: rtl/core/fragment_reassembly_tracker_core_macros.svh
// assertion macros for the fragment reassembly tracker checker
`ifndef FRAGMENT_REASSEMBLY_TRACKER_CORE_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_CORE_MACROS_SVH

// same-cycle implication, reset masked
`define FRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frt check failed");

// next-cycle implication, reset masked
`define FRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frt check failed");

`endif

FILE: rtl/core/frt_pkg.sv
// shared constants, types and helpers of the fragment reassembly tracker
`timescale 1ns / 1ps
`default_nettype none
package frt_pkg;
  localparam int SLOTS = 5;
  localparam int MAX_FRAG = 256;
  localparam int KEY_BITS = 64;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIT_W = $clog2(MAX_FRAG);
  localparam int CNT_W = $clog2(MAX_FRAG + 1);
  localparam logic [15:0] FULL_RESET = 16'd1024;

  typedef logic [MAX_FRAG-1:0] bitmap_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_BAD_SIZE = 3'd3,
    ST_DUP      = 3'd4,
    ST_NO_ALLOC = 3'd5
  } status_t;

  typedef struct packed {
    logic      en;
    slot_idx_t row;
    bitmap_t   data;
  } bm_wr_t;

  function automatic logic [23:0] sat24(input logic [32:0] v);
    sat24 = (v > 33'h0FF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/frt_bitmap_ram.sv
// received-fragment bitmap memory, one row per physical slot
`timescale 1ns / 1ps
`default_nettype none
module frt_bitmap_ram (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire frt_pkg::slot_idx_t rd_row,
  input  wire frt_pkg::bm_wr_t   wr,
  output frt_pkg::bitmap_t       rd_data
);
  frt_pkg::bitmap_t mem [frt_pkg::SLOTS];
  frt_pkg::bitmap_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

FILE: rtl/core/fragment_reassembly_tracker_core.sv
// top level of the fragment reassembly tracker
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | key, count, index, payload bytes
// out     | output    | out_valid/out_stall| status, slot, offset, total, evicted
// cfg     | input     | cfg_we             | full payload bytes
// one header goes through accept, slot lookup with bitmap row read, then update
// the bitmap memory read-modify-write sets these steps; a new header is taken after the update
// a stalled result waits in the output register; the update holds until it drains
// bitmap rows are rewritten on allocation, so reset needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module fragment_reassembly_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_message_key,
  input  wire logic [15:0] in_fragment_count,
  input  wire logic [15:0] in_fragment_index,
  input  wire logic [15:0] in_payload_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [2:0]       out_slot_used,
  output logic [23:0]      out_write_offset,
  output logic [23:0]      out_total_bytes,
  output logic             out_evicted,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  localparam int NS = frt_pkg::SLOTS;
  localparam int KB = frt_pkg::KEY_BITS;
  localparam int CW = frt_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] full_r;

  logic [KB-1:0] key_r;
  logic [15:0] cnt_r, idx_r, psz_r;
  logic hit_r, evict_r;
  frt_pkg::slot_idx_t slot_r, phys_r;
  logic [31:0] off_prod_r;
  logic [32:0] tot_prod_r;

  logic [CW-1:0] slot_count_r [NS];
  logic [KB-1:0] slot_key_r [NS];
  logic [23:0]   slot_total_r [NS];
  logic [CW-1:0] slot_recv_r [NS];
  frt_pkg::slot_idx_t slot_map_r [NS];

  logic [CW-1:0] slot_count_nxt [NS];
  logic [KB-1:0] slot_key_nxt [NS];
  logic [23:0]   slot_total_nxt [NS];
  logic [CW-1:0] slot_recv_nxt [NS];
  frt_pkg::slot_idx_t slot_map_nxt [NS];

  logic out_valid_r, out_evicted_r;
  frt_pkg::status_t out_status_r, st_nxt;
  logic [2:0] out_slot_r;
  logic [23:0] out_off_r, out_tot_r, tot_out_nxt;

  logic lk_hit, lk_free_found;
  frt_pkg::slot_idx_t lk_slot, lk_free;

  frt_pkg::bm_wr_t bm_wr;
  frt_pkg::bitmap_t bm_rd;

  logic upd_go, bad, is_last;
  logic [frt_pkg::BIT_W-1:0] bitpos;
  logic [23:0] off_sat, tot_sat, tot_val;
  logic [CW-1:0] recv_new;

  assign in_stall = (state_r != S_IDLE);
  assign upd_go = (state_r == S_UPD) && !(out_valid_r && out_stall);

  // slot search: first busy match, else highest free
  always_comb begin
    lk_hit = 1'b0;
    lk_free_found = 1'b0;
    lk_slot = '0;
    lk_free = '0;
    for (int s = 0; s < NS; s++) begin
      if (!lk_hit) begin
        if (slot_count_r[s] == '0) begin
          lk_free_found = 1'b1;
          lk_free = frt_pkg::SLOT_W'(s);
        end else if (slot_key_r[s] == key_r) begin
          lk_hit = 1'b1;
          lk_slot = frt_pkg::SLOT_W'(s);
        end
      end
    end
  end

  frt_bitmap_ram u_bitmap (
    .clk     (clk),
    .rd_en   (state_r == S_LOOK),
    .rd_row  (slot_map_r[lk_slot]),
    .wr      (bm_wr),
    .rd_data (bm_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: state_nxt = S_UPD;
      S_UPD: begin
        if (upd_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    slot_count_nxt = slot_count_r;
    slot_key_nxt = slot_key_r;
    slot_total_nxt = slot_total_r;
    slot_recv_nxt = slot_recv_r;
    slot_map_nxt = slot_map_r;
    st_nxt = frt_pkg::ST_STORED;
    tot_out_nxt = '0;
    bm_wr.en = 1'b0;
    bm_wr.row = phys_r;
    bm_wr.data = bm_rd;
    off_sat = frt_pkg::sat24({1'b0, off_prod_r});
    tot_sat = frt_pkg::sat24(tot_prod_r);
    bitpos = idx_r[frt_pkg::BIT_W-1:0];
    is_last = ({1'b0, idx_r} + 17'd1) == {1'b0, cnt_r};
    bad = (idx_r >= cnt_r) || (psz_r > full_r)
          || ((({1'b0, idx_r} + 17'd1) < {1'b0, cnt_r}) && (psz_r != full_r));
    recv_new = slot_recv_r[slot_r] + CW'(1);
    tot_val = is_last ? tot_sat : slot_total_r[slot_r];
    if (hit_r) begin
      if (cnt_r != 16'(slot_count_r[slot_r])) begin
        st_nxt = frt_pkg::ST_MISMATCH;
      end else if (bad) begin
        st_nxt = frt_pkg::ST_BAD_SIZE;
      end else if (bm_rd[bitpos]) begin
        st_nxt = frt_pkg::ST_DUP;
      end else begin
        bm_wr.en = 1'b1;
        bm_wr.data[bitpos] = 1'b1;
        slot_recv_nxt[slot_r] = recv_new;
        slot_total_nxt[slot_r] = tot_val;
        if (recv_new == cnt_r[CW-1:0]) begin
          st_nxt = frt_pkg::ST_COMPLETE;
          slot_count_nxt[slot_r] = '0;
          tot_out_nxt = tot_val;
        end
      end
    end else begin
      if (evict_r) begin
        for (int i = 0; i < NS - 1; i++) begin
          slot_count_nxt[i] = slot_count_r[i+1];
          slot_key_nxt[i] = slot_key_r[i+1];
          slot_total_nxt[i] = slot_total_r[i+1];
          slot_recv_nxt[i] = slot_recv_r[i+1];
          slot_map_nxt[i] = slot_map_r[i+1];
        end
        slot_map_nxt[NS-1] = slot_map_r[0];
        slot_count_nxt[NS-1] = '0;
      end
      if (cnt_r < 16'd2 || cnt_r > 16'(frt_pkg::MAX_FRAG)) begin
        st_nxt = frt_pkg::ST_NO_ALLOC;
      end else begin
        slot_count_nxt[slot_r] = cnt_r[CW-1:0];
        slot_key_nxt[slot_r] = key_r;
        slot_recv_nxt[slot_r] = '0;
        slot_total_nxt[slot_r] = '0;
        bm_wr.en = 1'b1;
        bm_wr.data = '0;
        if (bad) begin
          st_nxt = frt_pkg::ST_BAD_SIZE;
        end else begin
          bm_wr.data[bitpos] = 1'b1;
          slot_recv_nxt[slot_r] = CW'(1);
          slot_total_nxt[slot_r] = is_last ? tot_sat : 24'd0;
        end
      end
    end
    if (!upd_go) bm_wr.en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      full_r <= frt_pkg::FULL_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        slot_count_r[i] <= '0;
        slot_map_r[i] <= frt_pkg::SLOT_W'(i);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) full_r <= cfg_wdata;
      if (upd_go) begin
        out_valid_r <= 1'b1;
        slot_count_r <= slot_count_nxt;
        slot_map_r <= slot_map_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      key_r <= in_message_key[KB-1:0];
      cnt_r <= in_fragment_count;
      idx_r <= in_fragment_index;
      psz_r <= in_payload_bytes;
    end
    if (state_r == S_LOOK) begin
      hit_r <= lk_hit;
      evict_r <= !lk_hit && !lk_free_found;
      slot_r <= lk_hit ? lk_slot : (lk_free_found ? lk_free : frt_pkg::SLOT_W'(NS - 1));
      phys_r <= lk_hit ? slot_map_r[lk_slot]
              : (lk_free_found ? slot_map_r[lk_free] : slot_map_r[0]);
      off_prod_r <= idx_r * full_r;
      tot_prod_r <= 33'({16'd0, cnt_r - 16'd1} * {16'd0, full_r}) + {17'd0, psz_r};
    end
    if (upd_go) begin
      slot_key_r <= slot_key_nxt;
      slot_total_r <= slot_total_nxt;
      slot_recv_r <= slot_recv_nxt;
      out_status_r <= st_nxt;
      out_slot_r <= 3'(slot_r);
      out_evicted_r <= !hit_r && evict_r;
      out_tot_r <= tot_out_nxt;
      out_off_r <= (st_nxt == frt_pkg::ST_STORED || st_nxt == frt_pkg::ST_COMPLETE
                    || st_nxt == frt_pkg::ST_DUP) ? off_sat : 24'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot_used = out_slot_r;
  assign out_write_offset = out_off_r;
  assign out_total_bytes = out_tot_r;
  assign out_evicted = out_evicted_r;
endmodule
`default_nettype wire

FILE: rtl/core/frt_checker.sv
// port-level checker for the fragment reassembly tracker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "fragment_reassembly_tracker_core_macros.svh"
module frt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [23:0] out_write_offset,
  input wire logic [23:0] out_total_bytes,
  input wire logic        out_evicted
);
  logic not_complete, reject_status, miss_status;

  assign not_complete = out_status != frt_pkg::ST_COMPLETE;
  assign reject_status = out_status == frt_pkg::ST_MISMATCH
                         || out_status == frt_pkg::ST_BAD_SIZE
                         || out_status == frt_pkg::ST_NO_ALLOC;
  assign miss_status = out_status == frt_pkg::ST_STORED
                       || out_status == frt_pkg::ST_BAD_SIZE
                       || out_status == frt_pkg::ST_NO_ALLOC;

  // a header transfer makes the block busy next cycle
  `FRT_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
  `FRT_ASSERT_NOW(a_total_only_complete, out_valid && not_complete, out_total_bytes == 24'd0)
  `FRT_ASSERT_NOW(a_offset_zero_on_reject, out_valid && reject_status, out_write_offset == 24'd0)
  // eviction only on a miss
  `FRT_ASSERT_NOW(a_evict_on_miss, out_valid && out_evicted, miss_status)
endmodule

bind fragment_reassembly_tracker_core frt_checker u_frt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_write_offset (out_write_offset),
  .out_total_bytes  (out_total_bytes),
  .out_evicted      (out_evicted)
);
`default_nettype wire

FILE: tb/fragment_reassembly_tracker_core_test.sv
// self-checking testbench for the fragment reassembly tracker core
`timescale 1ns / 1ps
`default_nettype none
module fragment_reassembly_tracker_core_test;
  typedef struct {
    logic [63:0] key;
    logic [15:0] cnt;
    logic [15:0] idx;
    logic [15:0] psz;
  } frag_t;

  typedef struct {
    frt_pkg::status_t status;
    logic [2:0]  slot;
    logic [23:0] offset;
    logic [23:0] total;
    logic        evicted;
  } verdict_t;

  typedef struct {
    frag_t    frag;
    logic     known;
    verdict_t want;
  } row_t;

  localparam int NSLOT = frt_pkg::SLOTS;
  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_message_key;
  logic [15:0] in_fragment_count;
  logic [15:0] in_fragment_index;
  logic [15:0] in_payload_bytes;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [2:0]  out_slot_used;
  logic [23:0] out_write_offset;
  logic [23:0] out_total_bytes;
  logic        out_evicted;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  fragment_reassembly_tracker_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_message_key(in_message_key), .in_fragment_count(in_fragment_count),
    .in_fragment_index(in_fragment_index), .in_payload_bytes(in_payload_bytes),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot_used(out_slot_used),
    .out_write_offset(out_write_offset), .out_total_bytes(out_total_bytes),
    .out_evicted(out_evicted),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // tracker mirror
  logic [15:0]                  full_bytes;
  logic [8:0]                   trk_count [NSLOT];
  logic [63:0]                  trk_key [NSLOT];
  logic [23:0]                  trk_total [NSLOT];
  logic [8:0]                   trk_seen [NSLOT];
  logic [frt_pkg::MAX_FRAG-1:0] trk_bits [NSLOT];

  verdict_t pending[$];
  int       errors;
  int       cycles;
  bit       hold_long;
  row_t     rows[$];
  logic [63:0] live_keys[8];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("fragment_reassembly_tracker_core verification failed");
      $finish;
    end
  end

  function automatic logic [23:0] clip24(input logic [39:0] v);
    return (v > 40'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  function automatic void clear_entry(input int s);
    trk_count[s] = '0;
    trk_key[s]   = '0;
    trk_total[s] = '0;
    trk_seen[s]  = '0;
    trk_bits[s]  = '0;
  endfunction

  function automatic frt_pkg::status_t mark_fragment(input int s, input frag_t f,
                                                     output logic [23:0] tot);
    logic [16:0] c;
    c = 17'(trk_count[s]);
    tot = '0;
    if (f.idx >= c || f.psz > full_bytes || (f.idx + 17'd1 < c && f.psz != full_bytes))
      return frt_pkg::ST_BAD_SIZE;
    if (trk_bits[s][f.idx[7:0]]) return frt_pkg::ST_DUP;
    trk_bits[s][f.idx[7:0]] = 1'b1;
    trk_seen[s] = trk_seen[s] + 9'd1;
    if (f.idx + 17'd1 == c)
      trk_total[s] = clip24(40'(c - 17'd1) * full_bytes + f.psz);
    if (trk_seen[s] == c) begin
      tot = trk_total[s];
      trk_count[s] = '0;
      return frt_pkg::ST_COMPLETE;
    end
    return frt_pkg::ST_STORED;
  endfunction

  function automatic verdict_t track_fragment(input frag_t f);
    verdict_t v;
    int hit, vacant;
    logic [23:0] tot;
    hit = -1;
    vacant = -1;
    tot = '0;
    v.evicted = 1'b0;
    for (int s = 0; s < NSLOT; s++) begin
      if (hit < 0) begin
        if (trk_count[s] == 0) vacant = s;
        else if (trk_key[s] == f.key) hit = s;
      end
    end
    if (hit >= 0) begin
      if (f.cnt != trk_count[hit]) v.status = frt_pkg::ST_MISMATCH;
      else v.status = mark_fragment(hit, f, tot);
    end else begin
      if (vacant < 0) begin
        for (int s = 0; s + 1 < NSLOT; s++) begin
          trk_count[s] = trk_count[s+1];
          trk_key[s]   = trk_key[s+1];
          trk_total[s] = trk_total[s+1];
          trk_seen[s]  = trk_seen[s+1];
          trk_bits[s]  = trk_bits[s+1];
        end
        vacant = NSLOT - 1;
        clear_entry(vacant);
        v.evicted = 1'b1;
      end
      hit = vacant;
      if (f.cnt < 2 || f.cnt > frt_pkg::MAX_FRAG) v.status = frt_pkg::ST_NO_ALLOC;
      else begin
        clear_entry(hit);
        trk_count[hit] = f.cnt[8:0];
        trk_key[hit] = f.key;
        v.status = mark_fragment(hit, f, tot);
      end
    end
    v.slot = hit[2:0];
    v.offset = (v.status inside {frt_pkg::ST_STORED, frt_pkg::ST_COMPLETE, frt_pkg::ST_DUP})
               ? clip24(40'(f.idx) * full_bytes) : 24'd0;
    v.total = (v.status == frt_pkg::ST_COMPLETE) ? tot : 24'd0;
    return v;
  endfunction

  task automatic send_fragment(input frag_t f, input bit known, input verdict_t want);
    verdict_t v;
    repeat ($urandom_range(0, 5)) @(posedge clk);
    in_valid          <= 1'b1;
    in_message_key    <= f.key;
    in_fragment_count <= f.cnt;
    in_fragment_index <= f.idx;
    in_payload_bytes  <= f.psz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = track_fragment(f);
    if (known && v != want) begin
      errors++;
      $display("%0t directed row disagrees with tracker mirror: want %p mirror %p",
               $time, want, v);
    end
    pending.push_back(v);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_wait();
    while (pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_full(input logic [15:0] val);
    drain_wait();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    full_bytes = val;
  endtask

  // result side
  initial begin
    int gap;
    verdict_t want;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_long = 0;
      end
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer status=%0d", $time, out_status);
      end else begin
        want = pending.pop_front();
        if (out_status != want.status || out_slot_used != want.slot ||
            out_write_offset != want.offset || out_total_bytes != want.total ||
            out_evicted != want.evicted) begin
          errors++;
          $display("%0t mismatch expected st=%0d slot=%0d off=%0h tot=%0h ev=%0b",
                   $time, want.status, want.slot, want.offset, want.total,
                   want.evicted);
          $display("%0t          actual   st=%0d slot=%0d off=%0h tot=%0h ev=%0b",
                   $time, out_status, out_slot_used, out_write_offset,
                   out_total_bytes, out_evicted);
        end
      end
    end
  end

  function automatic frag_t mk(input logic [63:0] k, input int c, input int i,
                               input int p);
    frag_t f;
    f.key = k; f.cnt = 16'(c); f.idx = 16'(i); f.psz = 16'(p);
    return f;
  endfunction

  function automatic verdict_t vd(input frt_pkg::status_t st, input int sl, input int off,
                                  input int tot, input bit ev);
    verdict_t v;
    v.status = st; v.slot = 3'(sl); v.offset = 24'(off); v.total = 24'(tot);
    v.evicted = ev;
    return v;
  endfunction

  task automatic add_row(input frag_t f, input bit known, input verdict_t v);
    row_t r;
    r.frag = f; r.known = known; r.want = v;
    rows.push_back(r);
  endtask

  // random well-formed message fragments with some noise
  task automatic random_fragment();
    frag_t f;
    int pick, c, i;
    pick = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0)
      live_keys[pick] = {$urandom, $urandom};
    c = (pick < 4) ? $urandom_range(2, 6) : $urandom_range(2, 12);
    if (pick == 7) c = ($urandom_range(0, 9) == 0) ? frt_pkg::MAX_FRAG : c;
    i = $urandom_range(0, c - 1);
    f = mk(live_keys[pick], c, i, (i == c - 1) ? $urandom_range(0, full_bytes)
                                               : full_bytes);
    case ($urandom_range(0, 19))
      0: f.cnt = 16'($urandom);
      1: f.idx = 16'($urandom);
      2: f.psz = 16'($urandom);
      3: f.key = {$urandom, $urandom};
      4: f.cnt = 16'($urandom_range(0, 1));
      default: ;
    endcase
    send_fragment(f, 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_message_key = 0;
    in_fragment_count = 0;
    in_fragment_index = 0;
    in_payload_bytes = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    errors = 0;
    cycles = 0;
    hold_long = 0;
    full_bytes = frt_pkg::FULL_RESET;
    for (int s = 0; s < NSLOT; s++) clear_entry(s);
    for (int k = 0; k < 8; k++) live_keys[k] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mk(64'hA, 2, 0, 1024), 1, vd(frt_pkg::ST_STORED, 4, 0, 0, 0));
    add_row(mk(64'hA, 2, 0, 1024), 1, vd(frt_pkg::ST_DUP, 4, 0, 0, 0));
    add_row(mk(64'hA, 3, 1, 10), 1, vd(frt_pkg::ST_MISMATCH, 4, 0, 0, 0));
    add_row(mk(64'hA, 2, 1, 10), 1, vd(frt_pkg::ST_COMPLETE, 4, 1024, 1034, 0));
    add_row(mk(64'hB, 1, 0, 5), 1, vd(frt_pkg::ST_NO_ALLOC, 4, 0, 0, 0));
    add_row(mk(64'hB, 257, 0, 5), 1, vd(frt_pkg::ST_NO_ALLOC, 4, 0, 0, 0));
    add_row(mk(64'hB, 4, 4, 5), 1, vd(frt_pkg::ST_BAD_SIZE, 4, 0, 0, 0));
    add_row(mk(64'hB, 4, 0, 1023), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    add_row(mk(64'hB, 4, 3, 1025), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    add_row(mk(64'hFFFF_FFFF_FFFF_FFFF, 256, 255, 1024), 0,
            vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    add_row(mk(64'h0, 65535, 65535, 65535), 1, vd(frt_pkg::ST_NO_ALLOC, 2, 0, 0, 0));
    add_row(mk(64'hC, 2, 0, 1024), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    add_row(mk(64'hD, 2, 0, 1024), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    add_row(mk(64'hE, 2, 0, 1024), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    add_row(mk(64'hF, 0, 0, 0), 1, vd(frt_pkg::ST_NO_ALLOC, 4, 0, 0, 1));
    add_row(mk(64'h10, 3, 2, 0), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    foreach (rows[n]) send_fragment(rows[n].frag, rows[n].known, rows[n].want);

    // extremes of the register
    set_full(16'hFFFF);
    send_fragment(mk(64'h20, 256, 255, 65535), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    send_fragment(mk(64'h20, 256, 0, 65535), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));
    set_full(16'd1);
    for (int n = 0; n < 3; n++)
      send_fragment(mk(64'h30, 3, n, 1), 0, vd(frt_pkg::ST_STORED, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_full(16'd8);
        1: set_full(16'($urandom_range(1, 65535)));
        2: set_full(16'd1024);
        default: set_full(16'd1);
      endcase
      for (int n = 0; n < 200; n++) begin
        if (ph == 1 && n == 20) hold_long = 1;
        if (n == 100) drain_wait();
        random_fragment();
      end
    end

    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("fragment_reassembly_tracker_core verification clean");
    end else begin
      $display("fragment_reassembly_tracker_core verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
